// File: rtl/frame_allocator_with_byte_store_macros.svh
// Assertion macros used by the checker file of the frame allocator.
`ifndef FRAME_ALLOCATOR_WITH_BYTE_STORE_MACROS_SVH
`define FRAME_ALLOCATOR_WITH_BYTE_STORE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define FABS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Property checked at every clock edge, reset included.
`define FABS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/fabs_pkg.sv
`timescale 1ns / 1ps
package fabs_pkg;

  // Store geometry. Both counts are powers of two.
  localparam int MAX_FRAMES  = 64;
  localparam int PAGE_BYTES  = 256;
  localparam int STORE_BYTES = MAX_FRAMES * PAGE_BYTES;

  localparam int FRAME_W  = $clog2(MAX_FRAMES);
  localparam int CNT_W    = $clog2(MAX_FRAMES + 1);
  localparam int PAGE_W   = $clog2(PAGE_BYTES);
  localparam int ADDR_W   = $clog2(STORE_BYTES);
  localparam int DATA_W   = 8;
  localparam int ACT_W    = 3;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 7;

  // Stream word widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = ((FRAME_W + ADDR_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((FRAME_W + DATA_W + 7) / 8) * 8;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [DATA_W-1:0]  byte_t;

  // Frame count after reset.
  localparam count_t RESET_FRAMES = count_t'((MAX_FRAMES < 64) ? MAX_FRAMES : 64);

  typedef enum logic [ACT_W-1:0] {
    ACT_TAKE    = 3'd0,
    ACT_RELEASE = 3'd1,
    ACT_READ    = 3'd2,
    ACT_WRITE   = 3'd3,
    ACT_ZERO    = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_NO_FREE     = 3'd1,
    STAT_BAD_FRAME   = 3'd2,
    STAT_DOUBLE_FREE = 3'd3,
    STAT_BAD_ADDR    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_RELEASE,
    S_READ,
    S_ZERO
  } state_e;

  // Commands from the sequencer to the free list.
  typedef struct packed {
    logic   init;
    logic   take_rd;
    logic   take_wr;
    logic   rel_rd;
    logic   rel_wr;
    frame_t frame;
    count_t frames;
  } fl_cmd_t;

  // Free list status seen by the sequencer.
  typedef struct packed {
    logic   empty;
    frame_t head_frame;
    logic   frame_free;
  } fl_stat_t;

  // Commands from the sequencer to the byte store.
  typedef struct packed {
    logic   rd;
    logic   wr;
    logic   zero;
    addr_t  addr;
    byte_t  wdata;
    frame_t page;
  } st_cmd_t;

  // Queue index that a frame count wraps to.
  function automatic frame_t wrap_count(count_t n);
    frame_t r;
    r = (int'(n) == MAX_FRAMES) ? '0 : FRAME_W'(n);
    return r;
  endfunction

endpackage

// File: rtl/frame_allocator_with_byte_store.sv
`timescale 1ns / 1ps
// Frame allocator with a byte store: a 64-frame, 256-byte-page memory with a FIFO list of
// free frames. Each input word carries one request (take, release, read byte, write byte,
// zero page) and produces exactly one result word with a status code. One request is in
// flight at a time. Errors, writes and unknown actions produce their result at the accept
// edge; take, release and read produce it in the cycle after, from the registered read of
// the free list or store memory; zero page clears one byte per cycle through the single
// store write port and produces its result when that sweep ends. After reset the store is
// cleared by a sweep of all MAX_FRAMES * PAGE_BYTES (16384) bytes during which no request
// is accepted. The frames_in_use register may be written at any time the block is idle,
// including during the sweep; it is registered and resets the free list, not the store.
module frame_allocator_with_byte_store (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration: frames_in_use.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fabs_pkg::CFG_W-1:0]          cfg_data_i,
  // Request stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata from bit 0: frame_sel, byte_address, write_data, zero fill.
  input  logic [fabs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: action.
  input  logic [fabs_pkg::ACT_W-1:0]          s_axis_tuser,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata from bit 0: granted_frame, read_data, zero fill.
  output logic [fabs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // tuser: status.
  output logic [fabs_pkg::STATUS_W-1:0]       m_axis_tuser
);
  import fabs_pkg::*;

  state_e   state_q, state_d;
  count_t   frames_q, frames_d;
  frame_t   frame_q, frame_d;

  logic     out_valid_q, out_valid_d;
  status_e  status_q;
  frame_t   granted_q;
  byte_t    rdata_q;

  logic     load;
  status_e  res_status;
  frame_t   res_granted;
  byte_t    res_rdata;

  fl_cmd_t  fl_cmd;
  fl_stat_t fl_stat;
  st_cmd_t  st_cmd;
  byte_t    st_rdata;
  logic     st_busy;

  logic     in_fire;
  logic     cfg_fire;
  action_e  in_action;
  frame_t   in_frame;
  addr_t    in_addr;
  byte_t    in_wdata;
  logic     frame_bad;
  logic     addr_bad;
  count_t   cfg_frames;

  function automatic count_t clamp_frames(logic [CFG_W-1:0] v);
    count_t r;
    if (v == '0) begin
      r = count_t'(1);
    end else if (int'(v) > MAX_FRAMES) begin
      r = count_t'(MAX_FRAMES);
    end else begin
      r = count_t'(v);
    end
    return r;
  endfunction

  // Unpack the request word.
  assign in_action = action_e'(s_axis_tuser);
  assign in_frame  = s_axis_tdata[FRAME_W-1:0];
  assign in_addr   = s_axis_tdata[FRAME_W +: ADDR_W];
  assign in_wdata  = s_axis_tdata[FRAME_W+ADDR_W +: DATA_W];

  assign frame_bad = ({1'b0, in_frame} >= frames_q);
  assign addr_bad  = ({1'b0, in_addr[ADDR_W-1:PAGE_W]} >= frames_q);

  // A request is taken only when idle, after the clearing sweep, with the result slot free.
  assign s_axis_tready = (state_q == S_IDLE) && !st_busy && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign cfg_frames    = clamp_frames(cfg_data_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ACT_TAKE:    if (!fl_stat.empty) state_d = S_TAKE;
            ACT_RELEASE: if (!frame_bad) state_d = S_RELEASE;
            ACT_READ:    if (!addr_bad) state_d = S_READ;
            ACT_ZERO:    if (!frame_bad) state_d = S_ZERO;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_TAKE, S_RELEASE, S_READ: state_d = S_IDLE;
      S_ZERO: if (!st_busy) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the memories and the result of each step.
  always_comb begin
    fl_cmd        = '0;
    fl_cmd.frames = frames_q;
    st_cmd        = '0;
    st_cmd.addr   = in_addr;
    st_cmd.wdata  = in_wdata;
    st_cmd.page   = in_frame;
    frames_d      = frames_q;
    frame_d       = frame_q;
    load          = 1'b0;
    res_status    = STAT_OK;
    res_granted   = '0;
    res_rdata     = '0;

    if (cfg_fire) begin
      frames_d      = cfg_frames;
      fl_cmd.init   = 1'b1;
      fl_cmd.frames = cfg_frames;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          frame_d      = in_frame;
          fl_cmd.frame = in_frame;
          case (in_action)
            ACT_TAKE: begin
              if (fl_stat.empty) begin
                load       = 1'b1;
                res_status = STAT_NO_FREE;
              end else begin
                fl_cmd.take_rd = 1'b1;
              end
            end
            ACT_RELEASE: begin
              if (frame_bad) begin
                load       = 1'b1;
                res_status = STAT_BAD_FRAME;
              end else begin
                fl_cmd.rel_rd = 1'b1;
              end
            end
            ACT_READ: begin
              if (addr_bad) begin
                load       = 1'b1;
                res_status = STAT_BAD_ADDR;
              end else begin
                st_cmd.rd = 1'b1;
              end
            end
            ACT_WRITE: begin
              load = 1'b1;
              if (addr_bad) begin
                res_status = STAT_BAD_ADDR;
              end else begin
                st_cmd.wr = 1'b1;
              end
            end
            ACT_ZERO: begin
              if (frame_bad) begin
                load       = 1'b1;
                res_status = STAT_BAD_FRAME;
              end else begin
                st_cmd.zero = 1'b1;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_TAKE: begin
        fl_cmd.take_wr = 1'b1;
        fl_cmd.frame   = fl_stat.head_frame;
        load           = 1'b1;
        res_granted    = fl_stat.head_frame;
      end
      S_RELEASE: begin
        fl_cmd.frame = frame_q;
        load         = 1'b1;
        if (fl_stat.frame_free) begin
          res_status = STAT_DOUBLE_FREE;
        end else begin
          fl_cmd.rel_wr = 1'b1;
        end
      end
      S_READ: begin
        load      = 1'b1;
        res_rdata = st_rdata;
      end
      S_ZERO: begin
        load = !st_busy;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // Result slot: filled only when empty or drained in the same cycle.
  assign out_valid_d = (out_valid_q && !m_axis_tready) || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      frames_q    <= RESET_FRAMES;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      frames_q    <= frames_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    if (load) begin
      status_q  <= res_status;
      granted_q <= res_granted;
      rdata_q   <= res_rdata;
    end
  end

  fabs_free_list u_free_list (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (fl_cmd),
    .stat_o (fl_stat)
  );

  fabs_byte_store u_byte_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (st_cmd),
    .rdata_o (st_rdata),
    .busy_o  (st_busy)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = OUT_DATA_W'({rdata_q, granted_q});

endmodule

// File: rtl/fabs_free_list.sv
`timescale 1ns / 1ps
module fabs_free_list (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fabs_pkg::fl_cmd_t  cmd_i,
  output fabs_pkg::fl_stat_t stat_o
);
  import fabs_pkg::*;

  frame_t queue_mem [MAX_FRAMES];
  logic   map_mem   [MAX_FRAMES];

  frame_t head_q, head_d;
  frame_t tail_q, tail_d;
  count_t total_q, total_d;
  logic [MAX_FRAMES-1:0] q_written_q, q_written_d;
  logic [MAX_FRAMES-1:0] m_written_q, m_written_d;

  frame_t q_rdata_q;
  logic   q_rwritten_q;
  frame_t q_ridx_q;
  logic   m_rdata_q;
  logic   m_rwritten_q;
  logic   m_rdflt_q;

  function automatic frame_t next_frame(frame_t f);
    frame_t r;
    r = (f == FRAME_W'(MAX_FRAMES - 1)) ? '0 : f + 1'b1;
    return r;
  endfunction

  // Pointer, count and written-mark updates.
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    total_d     = total_q;
    q_written_d = q_written_q;
    m_written_d = m_written_q;
    if (cmd_i.init) begin
      head_d      = '0;
      tail_d      = wrap_count(cmd_i.frames);
      total_d     = cmd_i.frames;
      q_written_d = '0;
      m_written_d = '0;
    end else if (cmd_i.take_wr) begin
      head_d                   = next_frame(head_q);
      total_d                  = total_q - 1'b1;
      m_written_d[cmd_i.frame] = 1'b1;
    end else if (cmd_i.rel_wr) begin
      tail_d                   = next_frame(tail_q);
      total_d                  = total_q + 1'b1;
      q_written_d[tail_q]      = 1'b1;
      m_written_d[cmd_i.frame] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= wrap_count(RESET_FRAMES);
      total_q     <= RESET_FRAMES;
      q_written_q <= '0;
      m_written_q <= '0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      total_q     <= total_d;
      q_written_q <= q_written_d;
      m_written_q <= m_written_d;
    end
  end

  // Queue memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rel_wr) begin
      queue_mem[tail_q] <= cmd_i.frame;
    end
    if (cmd_i.take_rd) begin
      q_rdata_q    <= queue_mem[head_q];
      q_rwritten_q <= q_written_q[head_q];
      q_ridx_q     <= head_q;
    end
  end

  // Free bitmap memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_wr || cmd_i.rel_wr) begin
      map_mem[cmd_i.frame] <= cmd_i.rel_wr;
    end
    if (cmd_i.rel_rd) begin
      m_rdata_q    <= map_mem[cmd_i.frame];
      m_rwritten_q <= m_written_q[cmd_i.frame];
      m_rdflt_q    <= ({1'b0, cmd_i.frame} < cmd_i.frames);
    end
  end

  // An entry not written since the last init reads as its initial value.
  assign stat_o.empty      = (total_q == '0);
  assign stat_o.head_frame = q_rwritten_q ? q_rdata_q : q_ridx_q;
  assign stat_o.frame_free = m_rwritten_q ? m_rdata_q : m_rdflt_q;

endmodule

// File: rtl/fabs_byte_store.sv
`timescale 1ns / 1ps
module fabs_byte_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fabs_pkg::st_cmd_t cmd_i,
  output fabs_pkg::byte_t   rdata_o,
  output logic              busy_o
);
  import fabs_pkg::*;

  byte_t store_mem [STORE_BYTES];
  byte_t rdata_q;

  logic  sweep_q, sweep_d;
  addr_t swp_addr_q, swp_addr_d;
  addr_t swp_last_q, swp_last_d;
  addr_t page_base;

  logic  wr_en;
  addr_t wr_addr;
  byte_t wr_data;

  assign page_base = addr_t'(addr_t'(cmd_i.page) << PAGE_W);

  // Zeroing sweep: the whole store after reset, one page on request.
  always_comb begin
    sweep_d    = sweep_q;
    swp_addr_d = swp_addr_q;
    swp_last_d = swp_last_q;
    if (sweep_q) begin
      swp_addr_d = swp_addr_q + 1'b1;
      if (swp_addr_q == swp_last_q) begin
        sweep_d = 1'b0;
      end
    end else if (cmd_i.zero) begin
      sweep_d    = 1'b1;
      swp_addr_d = page_base;
      swp_last_d = page_base + addr_t'(PAGE_BYTES - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q    <= 1'b1;
      swp_addr_q <= '0;
      swp_last_q <= addr_t'(STORE_BYTES - 1);
    end else begin
      sweep_q    <= sweep_d;
      swp_addr_q <= swp_addr_d;
      swp_last_q <= swp_last_d;
    end
  end

  // The sweep owns the write port while it runs.
  assign wr_en   = sweep_q | cmd_i.wr;
  assign wr_addr = sweep_q ? swp_addr_q : cmd_i.addr;
  assign wr_data = sweep_q ? '0 : cmd_i.wdata;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      rdata_q <= store_mem[cmd_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = sweep_q;

endmodule

// File: rtl/fabs_checker.sv
`timescale 1ns / 1ps
`include "frame_allocator_with_byte_store_macros.svh"
module fabs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [fabs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [fabs_pkg::STATUS_W-1:0]   m_axis_tuser
);
  import fabs_pkg::*;

  // A stalled result word holds until it is taken.
  `FABS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")

  // A failed request returns no frame and no data.
  `FABS_ASSERT(a_err_zero, m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> m_axis_tdata == '0, "error result carries nonzero data")

  // The store clearing sweep blocks requests right after reset.
  `FABS_ASSERT_ALWAYS(a_sweep_block, $rose(rst_ni) |-> !s_axis_tready, "request accepted during clearing sweep")

endmodule

bind frame_allocator_with_byte_store fabs_checker u_fabs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
